// ===== rtl/ngmf_pkg.sv =====
// ngmf_pkg: shared types, widths and register codes of the noise gated matched filter
// used by every module under rtl, no dependencies of its own
package ngmf_pkg;

   // filter geometry
   localparam int TAP_COUNT = 10;
   localparam int SAMPLE_W = 16;
   localparam int TAP_W = 8;
   localparam int THRESH_W = 15;
   localparam int HALF_W = 40;
   localparam int TAPS_W = TAP_COUNT * TAP_W;
   localparam int PROD_W = SAMPLE_W + TAP_W;
   localparam int ACC_W = PROD_W + $clog2(TAP_COUNT);
   localparam int FILL_W = $clog2(TAP_COUNT + 1);
   localparam int IDX_W = $clog2(TAP_COUNT);
   localparam int MAG_W = SAMPLE_W + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_LO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_HI = 2'd2;

   // reset values
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd1000;
   localparam logic [HALF_W-1:0] TAPS_HALF_RESET = 40'h0101010101;

   // output saturation limits
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

   // classified item handed from front to back
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_i;
      logic frame_start;
      logic pass;
   } ngmf_item_type;

endpackage

// ===== rtl/ngmf_front.sv =====
// ngmf_front: accepts samples, applies the noise gate and drops items that leave no trace
// depends on ngmf_pkg
module ngmf_front (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [31:0] req_tdata,   // sample_i [15:0], sample_q [31:16]
   input  logic req_tuser,          // frame_start
   input  logic [ngmf_pkg::THRESH_W-1:0] threshold,
   output logic push_valid,
   output ngmf_pkg::ngmf_item_type push_item,
   input  logic queue_full
);
   import ngmf_pkg::*;

   logic signed [SAMPLE_W-1:0] si;
   logic signed [SAMPLE_W-1:0] sq;
   logic [MAG_W-1:0] mag_i;
   logic [MAG_W-1:0] mag_q;
   logic pass;
   logic take;
   logic keep;
   logic item_valid_ff;
   logic item_valid_in;
   ngmf_item_type item_ff;
   ngmf_item_type item_in;

   // magnitude on 17 bits so full-scale negative gives 32768
   always_comb begin
      si = req_tdata[15:0];
      sq = req_tdata[31:16];
      mag_i = si[SAMPLE_W-1] ? MAG_W'(-MAG_W'(si)) : MAG_W'(si);
      mag_q = sq[SAMPLE_W-1] ? MAG_W'(-MAG_W'(sq)) : MAG_W'(sq);
      pass = (mag_i > MAG_W'(threshold)) || (mag_q > MAG_W'(threshold));
   end

   // one holding stage toward the queue
   assign req_tready = !item_valid_ff || !queue_full;
   assign take = req_tvalid && req_tready;
   assign keep = pass || req_tuser;
   assign push_valid = item_valid_ff;
   assign push_item = item_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in = item_ff;
      if (item_valid_ff && !queue_full) begin
         item_valid_in = 1'b0;
      end
      if (take && keep) begin
         item_valid_in = 1'b1;
         item_in.sample_i = si;
         item_in.frame_start = req_tuser;
         item_in.pass = pass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== rtl/ngmf_queue.sv =====
// ngmf_queue: short first-in first-out queue of classified items between front and back
// depends on ngmf_pkg
module ngmf_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  ngmf_pkg::ngmf_item_type push_item,
   output logic full,
   input  logic pop,
   output logic not_empty,
   output ngmf_pkg::ngmf_item_type pop_item
);
   import ngmf_pkg::*;

   ngmf_item_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic do_push;
   logic do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/ngmf_back.sv =====
// ngmf_back: sample window, shared multiply-accumulate sequencer, saturation and result register
// depends on ngmf_pkg
module ngmf_back (
   input  logic clock,
   input  logic reset,
   input  logic queue_not_empty,
   input  ngmf_pkg::ngmf_item_type queue_item,
   output logic queue_pop,
   input  logic [ngmf_pkg::TAPS_W-1:0] taps,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_tdata,   // filtered_value
   output logic rsp_tuser           // clipped
);
   import ngmf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SAT_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SAT_MIN);

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] fill_base;
   logic [FILL_W-1:0] cnt_ff;
   logic [FILL_W-1:0] cnt_in;
   logic [IDX_W-1:0] idx;
   logic signed [SAMPLE_W-1:0] window_ff [TAP_COUNT];
   logic shift;
   logic signed [SAMPLE_W-1:0] win_sel;
   logic signed [TAP_W-1:0] tap_sel;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic signed [SAMPLE_W-1:0] out_value_ff;
   logic signed [SAMPLE_W-1:0] out_value_in;
   logic out_clip_ff;
   logic out_clip_in;
   logic out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_value_ff;
   assign rsp_tuser = out_clip_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   // operand select for the shared multiplier, oldest sample first
   always_comb begin
      idx = (cnt_ff < FILL_W'(TAP_COUNT)) ? cnt_ff[IDX_W-1:0] : '0;
      win_sel = window_ff[idx];
      tap_sel = taps[idx*TAP_W +: TAP_W];
      prod_in = PROD_W'(win_sel) * PROD_W'(tap_sel);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      queue_pop = 1'b0;
      shift = 1'b0;
      fill_base = queue_item.frame_start ? '0 : fill_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_clip_in = out_clip_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_not_empty) begin
               queue_pop = 1'b1;
               fill_in = fill_base;
               if (queue_item.pass) begin
                  shift = 1'b1;
                  if (fill_base != FILL_W'(TAP_COUNT)) begin
                     fill_in = FILL_W'(fill_base + 1'b1);
                  end
                  if (fill_in == FILL_W'(TAP_COUNT)) begin
                     state_in = ST_MAC;
                     cnt_in = '0;
                  end
               end
            end
         end
         ST_MAC: begin
            // product of the previous step is registered in prod_ff before it joins the sum
            acc_in = (cnt_ff == '0) ? '0 : ACC_W'(acc_ff + ACC_W'(prod_ff));
            cnt_in = FILL_W'(cnt_ff + 1'b1);
            if (cnt_ff == FILL_W'(TAP_COUNT)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (acc_ff > ACC_MAX) begin
                  out_value_in = SAT_MAX;
                  out_clip_in = 1'b1;
               end else if (acc_ff < ACC_MIN) begin
                  out_value_in = SAT_MIN;
                  out_clip_in = 1'b1;
               end else begin
                  out_value_in = acc_ff[SAMPLE_W-1:0];
                  out_clip_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      out_value_ff <= out_value_in;
      out_clip_ff <= out_clip_in;
   end

   // window shift line, newest sample at the top
   always_ff @(posedge clock) begin
      if (shift) begin
         for (int k = 0; k < TAP_COUNT - 1; k++) begin
            window_ff[k] <= window_ff[k+1];
         end
         window_ff[TAP_COUNT-1] <= queue_item.sample_i;
      end
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TAP_COUNT))
      else $error("window fill beyond tap count");
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC || state_ff == ST_DONE) |-> fill_ff == FILL_W'(TAP_COUNT))
      else $error("sum running on a window that is not full");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> state_ff == ST_IDLE)
      else $error("queue popped while a sum is in progress");
   a_result_after_mac: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result shown without a finished sum");
`endif

endmodule

// ===== rtl/noise_gated_matched_filter.sv =====
// noise_gated_matched_filter: top level with configuration registers, front, queue and back
// depends on ngmf_pkg, ngmf_front, ngmf_queue, ngmf_back
//
// The front takes a sample while its holding stage is empty or the queue is not full; it
// compares |I| and |Q| against the threshold and drops rejected samples that carry no frame
// start. Kept items wait in a four-entry queue. The back shifts the I value of each passing
// item into a ten-sample window and, once the window is full, runs ten multiply-accumulates
// on one shared 16x8 multiplier, oldest sample against tap 0, then saturates. The back pops
// no item while a sum is running, so this sequencer sets the sustained rate. Items that give
// no result are popped without starting a sum. The result stays in its output register
// while the next items are already accepted.
module noise_gated_matched_filter (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [31:0] req_tdata,   // sample_i [15:0], sample_q [31:16]
   input  logic req_tuser,          // frame_start
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_tdata,   // filtered_value
   output logic rsp_tuser,          // clipped
   input  logic csr_we,
   input  logic [ngmf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ngmf_pkg::HALF_W-1:0] csr_wdata
);
   import ngmf_pkg::*;

   logic [THRESH_W-1:0] threshold_ff;
   logic [HALF_W-1:0] taps_lo_ff;
   logic [HALF_W-1:0] taps_hi_ff;
   logic [2*HALF_W-1:0] taps_all;
   logic push_valid;
   ngmf_item_type push_item;
   logic queue_full;
   logic queue_pop;
   logic queue_not_empty;
   ngmf_item_type queue_item;

   // configuration registers, indexes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         taps_lo_ff <= TAPS_HALF_RESET;
         taps_hi_ff <= TAPS_HALF_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_TAPS_LO: taps_lo_ff <= csr_wdata;
            CSR_TAPS_HI: taps_hi_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign taps_all = {taps_hi_ff, taps_lo_ff};

   ngmf_front u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .threshold(threshold_ff),
      .push_valid(push_valid),
      .push_item(push_item),
      .queue_full(queue_full)
   );

   ngmf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push_valid),
      .push_item(push_item),
      .full(queue_full),
      .pop(queue_pop),
      .not_empty(queue_not_empty),
      .pop_item(queue_item)
   );

   ngmf_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_not_empty(queue_not_empty),
      .queue_item(queue_item),
      .queue_pop(queue_pop),
      .taps(taps_all[TAPS_W-1:0]),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule
